FILE: hdl/rthv_pkg.sv
// rthv_pkg: shared types and constants for the RGB to hue/brightness pipeline.
// Used by rgb_to_hue_value_core; no dependencies.

package rthv_pkg;

  // Channel and arithmetic widths
  localparam int ChanW = 16;
  localparam int QuoW  = 14;   // hue offset within a sextant is at most one sixth turn
  localparam int NumW  = 30;   // |diff| * sixth turn
  localparam int ProdW = 33;   // max * (level + 1)

  // One sixth of a full turn and the dark/grey threshold
  localparam logic [ChanW-1:0] SixthTurn = 16'd10923;
  localparam logic [ChanW-1:0] DarkLimit = 16'd256;

  // Sextant bases
  localparam logic [ChanW-1:0] BaseRed   = 16'd0;
  localparam logic [ChanW-1:0] BaseGreen = 16'd21846;
  localparam logic [ChanW-1:0] BaseBlue  = 16'd43692;

  // Which channel holds the maximum
  localparam logic [1:0] SextRed   = 2'd0;
  localparam logic [1:0] SextGreen = 2'd1;
  localparam logic [1:0] SextBlue  = 2'd2;

  typedef logic [ChanW-1:0] chan_t;

  // Payload carried through the divider stages
  typedef struct packed {
    logic [NumW-1:0] rem;       // partial remainder
    logic [QuoW-1:0] quo;       // quotient bits found so far
    chan_t           dvs;       // delta = max - min
    logic            neg;       // channel difference was negative
    chan_t           base;      // sextant base
    logic            zero_hue;  // dark or grey pixel
    chan_t           bright;    // finished brightness
  } div_stage_t;

endpackage

FILE: hdl/rgb_to_hue_value_core.sv
// rgb_to_hue_value_core: pipelined RGB to hue/brightness converter.
// Depends on rthv_pkg (types, constants).
//
//  channel  ports                                   transaction when
//  -------  --------------------------------------  ------------------------
//  input    start, busy, in_red/green/blue/level    start && !busy at clk
//  result   out_valid, out_hue, out_brightness      out_valid at clk
//
// One pixel enters per cycle; busy is always low. The pipeline has three front
// stages (max/min, delta and difference, two multipliers), a restoring divider
// of 14 stages (one quotient bit each), and one output stage.
// The divider depth sets the latency. rst_n (synchronous) clears the valid
// bits only. Results are shown for one cycle and cannot be held off.

module rgb_to_hue_value_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [15:0] in_level,
  output logic        out_valid,
  output logic [15:0] out_hue,
  output logic [15:0] out_brightness
);

  localparam int DivStages = rthv_pkg::QuoW;

  // Never stalls
  assign busy = 1'b0;

  // ---------------- Stage A: max, min, difference operands ----------------
  logic           a_vld_r;
  rthv_pkg::chan_t a_mx_r, a_mn_r, a_pa_r, a_pb_r, a_lvl_r;
  logic [1:0]     a_sext_r;

  rthv_pkg::chan_t a_mx_nxt, a_mn_nxt, a_pa_nxt, a_pb_nxt;
  logic [1:0]     a_sext_nxt;
  logic           r_ge_g, r_ge_b, g_ge_b;

  always_comb begin
    r_ge_g = in_red >= in_green;
    r_ge_b = in_red >= in_blue;
    g_ge_b = in_green >= in_blue;
    // ties go to red, then green
    if (r_ge_g && r_ge_b) begin
      a_sext_nxt = rthv_pkg::SextRed;
      a_mx_nxt   = in_red;
      a_pa_nxt   = in_green;
      a_pb_nxt   = in_blue;
    end else if (g_ge_b) begin
      a_sext_nxt = rthv_pkg::SextGreen;
      a_mx_nxt   = in_green;
      a_pa_nxt   = in_blue;
      a_pb_nxt   = in_red;
    end else begin
      a_sext_nxt = rthv_pkg::SextBlue;
      a_mx_nxt   = in_blue;
      a_pa_nxt   = in_red;
      a_pb_nxt   = in_green;
    end
    // minimum
    if (!r_ge_g && !r_ge_b) begin
      a_mn_nxt = in_red;
    end else if (!g_ge_b) begin
      a_mn_nxt = in_green;
    end else begin
      a_mn_nxt = in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
    a_mx_r   <= a_mx_nxt;
    a_mn_r   <= a_mn_nxt;
    a_pa_r   <= a_pa_nxt;
    a_pb_r   <= a_pb_nxt;
    a_lvl_r  <= in_level;
    a_sext_r <= a_sext_nxt;
  end

  // ---------------- Stage B: delta, |diff|, flags, base ----------------
  logic            b_vld_r;
  rthv_pkg::chan_t b_mag_r, b_dlt_r, b_base_r, b_mx_r, b_lvl_r;
  logic            b_neg_r, b_dark_r, b_zero_r;

  rthv_pkg::chan_t b_mag_nxt, b_dlt_nxt, b_base_nxt;
  logic            b_neg_nxt, b_dark_nxt, b_zero_nxt;

  always_comb begin
    b_dlt_nxt  = a_mx_r - a_mn_r;
    b_neg_nxt  = a_pa_r < a_pb_r;
    b_mag_nxt  = b_neg_nxt ? (a_pb_r - a_pa_r) : (a_pa_r - a_pb_r);
    b_dark_nxt = (a_lvl_r <= rthv_pkg::DarkLimit) || (a_mx_r <= rthv_pkg::DarkLimit);
    b_zero_nxt = b_dark_nxt || (b_dlt_nxt <= rthv_pkg::DarkLimit);
    case (a_sext_r)
      rthv_pkg::SextRed:   b_base_nxt = rthv_pkg::BaseRed;
      rthv_pkg::SextGreen: b_base_nxt = rthv_pkg::BaseGreen;
      rthv_pkg::SextBlue:  b_base_nxt = rthv_pkg::BaseBlue;
      default:             b_base_nxt = rthv_pkg::BaseRed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_mag_r  <= b_mag_nxt;
    b_dlt_r  <= b_dlt_nxt;
    b_base_r <= b_base_nxt;
    b_mx_r   <= a_mx_r;
    b_lvl_r  <= a_lvl_r;
    b_neg_r  <= b_neg_nxt;
    b_dark_r <= b_dark_nxt;
    b_zero_r <= b_zero_nxt;
  end

  // ---------------- Stage C: numerator and brightness products ----------------
  logic [rthv_pkg::NumW-1:0]  c_num;
  logic [rthv_pkg::ProdW-1:0] c_prod;
  rthv_pkg::div_stage_t       div_r   [0:DivStages];
  rthv_pkg::div_stage_t       div_nxt [1:DivStages];
  logic [DivStages:0]         div_vld_r;

  always_comb begin
    c_num  = {{(rthv_pkg::NumW-rthv_pkg::ChanW){1'b0}}, b_mag_r} *
             {{(rthv_pkg::NumW-rthv_pkg::ChanW){1'b0}}, rthv_pkg::SixthTurn};
    c_prod = {17'd0, b_mx_r} * ({17'd0, b_lvl_r} + 33'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else begin
      div_vld_r[0] <= b_vld_r;
    end
    div_r[0].rem      <= c_num;
    div_r[0].quo      <= '0;
    div_r[0].dvs      <= b_dlt_r;
    div_r[0].neg      <= b_neg_r;
    div_r[0].base     <= b_base_r;
    div_r[0].zero_hue <= b_zero_r;
    div_r[0].bright   <= b_dark_r ? '0 : c_prod[31:16];
  end

  // ---------------- Divider: one quotient bit per stage, MSB first ----------------
  genvar gi;
  generate
    for (gi = 1; gi <= DivStages; gi++) begin : g_div
      localparam int Bit = DivStages - gi;
      logic [rthv_pkg::NumW-1:0] shifted;
      logic [rthv_pkg::NumW:0]   trial;

      always_comb begin
        shifted = rthv_pkg::NumW'(div_r[gi-1].dvs) << Bit;
        trial   = {1'b0, div_r[gi-1].rem} - {1'b0, shifted};
        div_nxt[gi] = div_r[gi-1];
        if (!trial[rthv_pkg::NumW]) begin
          div_nxt[gi].rem      = trial[rthv_pkg::NumW-1:0];
          div_nxt[gi].quo[Bit] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_vld_r[gi] <= 1'b0;
        end else begin
          div_vld_r[gi] <= div_vld_r[gi-1];
        end
        div_r[gi] <= div_nxt[gi];
      end
    end
  endgenerate

  // ---------------- Output stage: signed offset plus base ----------------
  logic            out_valid_r;
  rthv_pkg::chan_t out_hue_r, out_bright_r;
  rthv_pkg::chan_t quo_ext, out_hue_nxt;

  always_comb begin
    quo_ext = rthv_pkg::ChanW'(div_r[DivStages].quo);
    if (div_r[DivStages].zero_hue) begin
      out_hue_nxt = '0;
    end else if (div_r[DivStages].neg) begin
      out_hue_nxt = div_r[DivStages].base - quo_ext;   // wraps mod 2^16
    end else begin
      out_hue_nxt = div_r[DivStages].base + quo_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld_r[DivStages];
    end
    out_hue_r    <= out_hue_nxt;
    out_bright_r <= div_r[DivStages].bright;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_brightness = out_bright_r;

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for rgb_to_hue_value_core.
// Drives pixels by command handshake, predicts hue/brightness per pixel and
// compares every result in order. Depends on rthv_pkg and the core.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected hue/brightness pair for one pixel
  typedef struct {
    rthv_pkg::chan_t hue;
    rthv_pkg::chan_t bright;
  } hue_bright_t;

  // Scoreboard: predicts each accepted pixel and checks results in order
  class pixel_scoreboard;
    hue_bright_t expected_hue_q[$];
    int          mismatches;
    int          failures;

    function new();
      mismatches = 0;
      failures   = 0;
    endfunction

    // HSV hue on a 16-bit turn plus max channel scaled by level
    function automatic hue_bright_t predict_hue_bright(rthv_pkg::chan_t r,
                                                       rthv_pkg::chan_t g,
                                                       rthv_pkg::chan_t b,
                                                       rthv_pkg::chan_t lvl);
      longint      rr, gg, bb, mx, mn, delta, h, prod, sixth, dark;
      hue_bright_t res;
      rr    = longint'(r);
      gg    = longint'(g);
      bb    = longint'(b);
      sixth = longint'(rthv_pkg::SixthTurn);
      dark  = longint'(rthv_pkg::DarkLimit);
      mx = rr;
      mn = rr;
      if (gg > mx) mx = gg;
      if (bb > mx) mx = bb;
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      delta = mx - mn;
      prod  = mx * (longint'(lvl) + 1);
      res.bright = rthv_pkg::chan_t'(prod >> 16);
      res.hue    = '0;
      if (longint'(lvl) <= dark || mx <= dark) begin
        res.bright = '0;
      end else if (delta > dark) begin
        // ties go to red first, then green
        if (mx == rr) h = ((gg - bb) * sixth) / delta;
        else if (mx == gg) h = 2 * sixth + ((bb - rr) * sixth) / delta;
        else h = 4 * sixth + ((rr - gg) * sixth) / delta;
        h = h % 65536;
        if (h < 0) h += 65536;
        res.hue = rthv_pkg::chan_t'(h);
      end
      return res;
    endfunction

    function void note_pixel(rthv_pkg::chan_t r, rthv_pkg::chan_t g, rthv_pkg::chan_t b,
                             rthv_pkg::chan_t lvl);
      expected_hue_q.push_back(predict_hue_bright(r, g, b, lvl));
    endfunction

    function void check_result(rthv_pkg::chan_t hue, rthv_pkg::chan_t bright);
      hue_bright_t exp_hb;
      if (expected_hue_q.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result hue=%0d brightness=%0d", hue, bright);
        return;
      end
      exp_hb = expected_hue_q.pop_front();
      if (exp_hb.hue !== hue || exp_hb.bright !== bright) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: hue exp=%0d got=%0d, brightness exp=%0d got=%0d",
                   exp_hb.hue, hue, exp_hb.bright, bright);
      end
    endfunction

    function int pending();
      return expected_hue_q.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  rthv_pkg::chan_t in_red = '0;
  rthv_pkg::chan_t in_green = '0;
  rthv_pkg::chan_t in_blue = '0;
  rthv_pkg::chan_t in_level = '0;
  logic            out_valid;
  rthv_pkg::chan_t out_hue;
  rthv_pkg::chan_t out_brightness;

  pixel_scoreboard sb;
  bit              no_gaps;

  rgb_to_hue_value_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_brightness (out_brightness)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor: values sampled as they were before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_hue, out_brightness);
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One pixel transaction, then a random idle gap
  task automatic send_pixel(rthv_pkg::chan_t r, rthv_pkg::chan_t g, rthv_pkg::chan_t b,
                            rthv_pkg::chan_t lvl);
    int gap;
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_level <= lvl;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(r, g, b, lvl);
    gap = pick_gap();
    if (gap > 0) begin
      start    <= 1'b0;
      in_red   <= rthv_pkg::chan_t'($urandom);
      in_green <= rthv_pkg::chan_t'($urandom);
      in_blue  <= rthv_pkg::chan_t'($urandom);
      in_level <= rthv_pkg::chan_t'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random pixel, biased toward thresholds, ties and grey pixels
  task automatic send_random_pixel();
    rthv_pkg::chan_t c[3];
    rthv_pkg::chan_t lvl;
    rthv_pkg::chan_t top;
    int              kind;
    int              i;
    int              j;
    kind = $urandom_range(0, 9);
    lvl  = rthv_pkg::chan_t'($urandom);
    for (i = 0; i < 3; i++) c[i] = rthv_pkg::chan_t'($urandom);
    case (kind)
      5: begin
        for (i = 0; i < 3; i++) c[i] = rthv_pkg::chan_t'($urandom_range(0, 600));
        lvl = rthv_pkg::chan_t'($urandom_range(200, 320));
      end
      6: begin
        // two or three channels share the maximum
        top = rthv_pkg::chan_t'($urandom_range(0, 65535));
        i = $urandom_range(0, 2);
        j = (i + $urandom_range(1, 2)) % 3;
        c[i] = top;
        c[j] = top;
        if ($urandom_range(0, 3) == 0) c[3 - i - j] = top;
        else c[3 - i - j] = rthv_pkg::chan_t'($urandom_range(0, top));
      end
      7: begin
        // near-grey: spread around the threshold
        top = rthv_pkg::chan_t'($urandom_range(0, 65535 - 300));
        for (i = 0; i < 3; i++) c[i] = top + rthv_pkg::chan_t'($urandom_range(0, 300));
      end
      8: begin
        if ($urandom_range(0, 1)) lvl = rthv_pkg::chan_t'($urandom_range(0, 300));
        else lvl = rthv_pkg::chan_t'($urandom_range(65200, 65535));
      end
      9: begin
        for (i = 0; i < 3; i++) begin
          case ($urandom_range(0, 4))
            0: c[i] = 16'd0;
            1: c[i] = 16'hFFFF;
            2: c[i] = rthv_pkg::DarkLimit;
            3: c[i] = rthv_pkg::DarkLimit + 16'd1;
            default: c[i] = rthv_pkg::chan_t'($urandom);
          endcase
        end
      end
      default: ;
    endcase
    send_pixel(c[0], c[1], c[2], lvl);
  endtask

  // Main sequence
  initial begin
    int n;
    sb = new();
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, thresholds, ties, each sextant, hue wrap
    send_pixel(16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd256);
    send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd257);
    send_pixel(16'd256, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'd257, 16'd0, 16'd0, 16'hFFFF);
    send_pixel(16'd1000, 16'd744, 16'd800, 16'h8000);
    send_pixel(16'd1000, 16'd743, 16'd800, 16'h8000);
    send_pixel(16'd40000, 16'd10000, 16'd30000, 16'hC000);
    send_pixel(16'd40000, 16'd30000, 16'd10000, 16'hC000);
    send_pixel(16'd10000, 16'd50000, 16'd2000, 16'h7FFF);
    send_pixel(16'd2000, 16'd50000, 16'd10000, 16'h7FFF);
    send_pixel(16'd3000, 16'd500, 16'd60000, 16'h1234);
    send_pixel(16'd500, 16'd3000, 16'd60000, 16'h1234);
    send_pixel(16'd50000, 16'd50000, 16'd1000, 16'hFFFF);
    send_pixel(16'd1000, 16'd50000, 16'd50000, 16'hFFFF);
    send_pixel(16'd50000, 16'd1000, 16'd50000, 16'hFFFF);
    send_pixel(16'd65535, 16'd0, 16'd65535, 16'hAAAA);
    send_pixel(16'hAAAA, 16'h5555, 16'h0000, 16'h5555);
    send_pixel(16'h5555, 16'hAAAA, 16'hFFFF, 16'hAAAA);
    send_pixel(16'd65535, 16'd0, 16'd1, 16'd65535);

    // Random part, with stretches of back-to-back pixels
    for (n = 0; n < 900; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_random_pixel();
    end
    no_gaps = 1'b0;
    start <= 1'b0;

    // Drain the pipeline
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    sb.failures += sb.pending();
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
